/* rtl/ipv4_pkg.sv */
// ----------------------------------------------------------------------------
// IPv4 dotted-quad parser package
// Payload types, status codes and register map shared by the parser RTL.
// ----------------------------------------------------------------------------
`default_nettype none

package ipv4_pkg;

  // Status codes reported with each parsed string.
  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_WANT_DIGIT   = 3'd1;
  localparam logic [2:0] ST_WANT_DOT     = 3'd2;
  localparam logic [2:0] ST_RANGE        = 3'd3;
  localparam logic [2:0] ST_TRAILING     = 3'd4;
  localparam logic [2:0] ST_LEADING_ZERO = 3'd5;

  // Character and limit constants.
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [9:0] QUAD_LIMIT = 10'd255;
  localparam logic [7:0] POS_LIMIT  = 8'd255;

  // Register index of allow_leading_zero.
  localparam logic REG_ALLOW_LZ = 1'b0;

  // One input character.
  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } in_item_t;

  // One parse result.
  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  error_offset;
    logic [31:0] address;
    logic [31:0] reversed_address;
  } out_item_t;

endpackage : ipv4_pkg

`default_nettype wire

/* rtl/ipv4_dotted_quad_parser.sv */
// ----------------------------------------------------------------------------
// IPv4 dotted-quad parser
// Parses a text IPv4 address one character per transfer and reports one
// result per string with status, fault offset, address and reversed address.
// ----------------------------------------------------------------------------
// Usage:
//   The in_ channel carries one character per transfer; last_char marks the
//   final character of a string. A transfer happens when valid is high and
//   stall is low. The out_ channel carries one result per string, produced
//   for the transfer that carries last_char.
//   Throughput is one character per cycle while in_stall is low. Each character
//   is captured in an input register, and a single pass of compare and
//   digit-accumulate logic then updates the parse state and, for the last
//   character, loads the result register, which drives out_valid.
//   When the receiver stalls, the held result stays in the output register;
//   characters that cause no result keep flowing, and only a last character
//   waits in the input register until the output register frees up.
//   Reset (rst_n low, synchronous) clears both channels, the parse state and
//   allow_leading_zero. The register is written over the APB-style port
//   at byte address 0 and should only change while the parser is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4_dotted_quad_parser (
  input  wire                 clk,
  input  wire                 rst_n,
  // Input character channel
  input  wire                 in_valid,
  output logic                in_stall,
  input  ipv4_pkg::in_item_t  in_data,
  // Result channel
  output logic                out_valid,
  input  wire                 out_stall,
  output ipv4_pkg::out_item_t out_data,
  // Configuration port
  input  wire                 psel,
  input  wire                 penable,
  input  wire                 pwrite,
  input  wire  [2:0]          paddr,
  input  wire  [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  // Checks a finished quad: range first, then leading zero.
  function automatic logic [2:0] close_check(input logic [9:0] qv,
                                             input logic [1:0] dc,
                                             input logic       alz);
    logic [9:0] floor_val;
    floor_val = (dc == 2'd3) ? 10'd100 : 10'd10;
    if (qv > ipv4_pkg::QUAD_LIMIT) begin
      return ipv4_pkg::ST_RANGE;
    end else if (!alz && dc >= 2'd2 && qv < floor_val) begin
      return ipv4_pkg::ST_LEADING_ZERO;
    end
    return ipv4_pkg::ST_OK;
  endfunction

  // Configuration register.
  logic allow_lz_r;
  logic cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      allow_lz_r <= 1'b0;
    end else if (cfg_write && paddr[2] == ipv4_pkg::REG_ALLOW_LZ) begin
      allow_lz_r <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == ipv4_pkg::REG_ALLOW_LZ) ? {31'd0, allow_lz_r} : 32'd0;

  // Input register and output register handshake.
  logic               s1_valid_r;
  ipv4_pkg::in_item_t s1_data_r;
  logic               out_valid_r;
  ipv4_pkg::out_item_t out_data_r;
  logic               out_free;
  logic               process;

  assign out_free  = !out_valid_r || !out_stall;
  assign process   = s1_valid_r && (!s1_data_r.last_char || out_free);
  assign in_stall  = s1_valid_r && !process;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data_r <= in_data;
    end
  end

  // Parse state.
  logic        want_dot_r,   want_dot_nxt;
  logic [1:0]  quad_idx_r,   quad_idx_nxt;
  logic [1:0]  digit_cnt_r,  digit_cnt_nxt;
  logic [9:0]  quad_val_r,   quad_val_nxt;
  logic [31:0] addr_acc_r,   addr_acc_nxt;
  logic [7:0]  char_pos_r,   char_pos_nxt;
  logic [7:0]  tok_start_r,  tok_start_nxt;
  logic [2:0]  err_code_r,   err_code_nxt;
  logic [7:0]  err_pos_r,    err_pos_nxt;
  ipv4_pkg::out_item_t result;

  // One parsing step for the character in the input register.
  always_comb begin
    logic [7:0] c;
    logic [3:0] d;
    logic       is_digit;
    logic [2:0] chk;
    logic [7:0] pos;

    c   = s1_data_r.char_code;
    d   = 4'(c - ipv4_pkg::CHAR_ZERO);
    pos = char_pos_r;
    is_digit = c inside {[8'h30:8'h39]};

    want_dot_nxt  = want_dot_r;
    quad_idx_nxt  = quad_idx_r;
    digit_cnt_nxt = digit_cnt_r;
    quad_val_nxt  = quad_val_r;
    addr_acc_nxt  = addr_acc_r;
    tok_start_nxt = tok_start_r;
    err_code_nxt  = err_code_r;
    err_pos_nxt   = err_pos_r;
    chk           = ipv4_pkg::ST_OK;

    if (err_code_r == ipv4_pkg::ST_OK) begin
      if (!want_dot_r) begin
        if (is_digit) begin
          if (digit_cnt_r == 2'd0) begin
            tok_start_nxt = pos;
          end
          quad_val_nxt  = (quad_val_r << 3) + (quad_val_r << 1) + {6'd0, d};
          digit_cnt_nxt = digit_cnt_r + 2'd1;
          if (digit_cnt_nxt == 2'd3) begin
            // Third digit closes the quad.
            chk = close_check(quad_val_nxt, digit_cnt_nxt, allow_lz_r);
            if (chk != ipv4_pkg::ST_OK) begin
              err_code_nxt = chk;
              err_pos_nxt  = tok_start_nxt;
            end else begin
              addr_acc_nxt = {addr_acc_r[23:0], quad_val_nxt[7:0]};
              want_dot_nxt = 1'b1;
            end
            digit_cnt_nxt = 2'd0;
            quad_val_nxt  = 10'd0;
          end
        end else if (digit_cnt_r == 2'd0) begin
          err_code_nxt = ipv4_pkg::ST_WANT_DIGIT;
          err_pos_nxt  = pos;
        end else begin
          // Non-digit closes a short quad, then acts as a separator.
          chk = close_check(quad_val_r, digit_cnt_r, allow_lz_r);
          digit_cnt_nxt = 2'd0;
          quad_val_nxt  = 10'd0;
          if (chk != ipv4_pkg::ST_OK) begin
            err_code_nxt = chk;
            err_pos_nxt  = tok_start_r;
          end else begin
            addr_acc_nxt = {addr_acc_r[23:0], quad_val_r[7:0]};
            if (quad_idx_r == 2'd3) begin
              want_dot_nxt = 1'b1;
              err_code_nxt = ipv4_pkg::ST_TRAILING;
              err_pos_nxt  = pos;
            end else if (c == ipv4_pkg::CHAR_DOT) begin
              quad_idx_nxt = quad_idx_r + 2'd1;
              want_dot_nxt = 1'b0;
            end else begin
              want_dot_nxt = 1'b1;
              err_code_nxt = ipv4_pkg::ST_WANT_DOT;
              err_pos_nxt  = pos;
            end
          end
        end
      end else begin
        if (quad_idx_r == 2'd3) begin
          err_code_nxt = ipv4_pkg::ST_TRAILING;
          err_pos_nxt  = pos;
        end else if (c == ipv4_pkg::CHAR_DOT) begin
          quad_idx_nxt = quad_idx_r + 2'd1;
          want_dot_nxt = 1'b0;
        end else begin
          err_code_nxt = ipv4_pkg::ST_WANT_DOT;
          err_pos_nxt  = pos;
        end
      end
    end

    char_pos_nxt = (pos >= ipv4_pkg::POS_LIMIT) ? ipv4_pkg::POS_LIMIT : pos + 8'd1;

    // End of string: close an open quad, then check for a complete address.
    if (s1_data_r.last_char) begin
      if (err_code_nxt == ipv4_pkg::ST_OK && !want_dot_nxt && digit_cnt_nxt != 2'd0) begin
        chk = close_check(quad_val_nxt, digit_cnt_nxt, allow_lz_r);
        if (chk != ipv4_pkg::ST_OK) begin
          err_code_nxt = chk;
          err_pos_nxt  = tok_start_nxt;
        end else begin
          addr_acc_nxt = {addr_acc_nxt[23:0], quad_val_nxt[7:0]};
          want_dot_nxt = 1'b1;
        end
      end
      if (err_code_nxt == ipv4_pkg::ST_OK && !(want_dot_nxt && quad_idx_nxt == 2'd3)) begin
        err_code_nxt = want_dot_nxt ? ipv4_pkg::ST_WANT_DOT : ipv4_pkg::ST_WANT_DIGIT;
        err_pos_nxt  = char_pos_nxt;
      end
    end

    // Result word for a finished string.
    if (err_code_nxt == ipv4_pkg::ST_OK) begin
      result.status           = ipv4_pkg::ST_OK;
      result.error_offset     = 8'd0;
      result.address          = addr_acc_nxt;
      result.reversed_address = {addr_acc_nxt[7:0], addr_acc_nxt[15:8],
                                 addr_acc_nxt[23:16], addr_acc_nxt[31:24]};
    end else begin
      result.status           = err_code_nxt;
      result.error_offset     = err_pos_nxt;
      result.address          = 32'd0;
      result.reversed_address = 32'd0;
    end
  end

  // Parse state update; a finished string returns everything to reset values.
  always_ff @(posedge clk) begin
    if (!rst_n || (process && s1_data_r.last_char)) begin
      want_dot_r  <= 1'b0;
      quad_idx_r  <= 2'd0;
      digit_cnt_r <= 2'd0;
      quad_val_r  <= 10'd0;
      addr_acc_r  <= 32'd0;
      char_pos_r  <= 8'd0;
      tok_start_r <= 8'd0;
      err_code_r  <= ipv4_pkg::ST_OK;
      err_pos_r   <= 8'd0;
    end else if (process) begin
      want_dot_r  <= want_dot_nxt;
      quad_idx_r  <= quad_idx_nxt;
      digit_cnt_r <= digit_cnt_nxt;
      quad_val_r  <= quad_val_nxt;
      addr_acc_r  <= addr_acc_nxt;
      char_pos_r  <= char_pos_nxt;
      tok_start_r <= tok_start_nxt;
      err_code_r  <= err_code_nxt;
      err_pos_r   <= err_pos_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (process && s1_data_r.last_char) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (process && s1_data_r.last_char) begin
      out_data_r <= result;
    end
  end

endmodule : ipv4_dotted_quad_parser

`default_nettype wire
